// ===== design/text_console_writer_unit_defines.svh =====
// assertion macros shared by the console writer modules
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// checked outside reset
`define TCW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCW_ASSERT(label, clk, rst, prop, msg)
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== design/tcw_pkg.sv =====
// shared constants, codes and controller/datapath types of the console writer
// no dependencies
package tcw_pkg;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

  // port field widths
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int DATA_W = 16;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ATTR_W = 8;

  // screen store addressing and sweep counter
  localparam int CELL_AW = $clog2(SCREEN_CELLS);
  localparam int CNT_W   = $clog2(SCREEN_CELLS + 1);

  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(SCREEN_CELLS - 1);
  localparam logic [CNT_W-1:0] COPY_END   = CNT_W'(SCREEN_CELLS - SCREEN_COLS);
  localparam logic [CNT_W-1:0] ROW_STRIDE = CNT_W'(SCREEN_COLS);

  localparam logic [CHAR_W-1:0] CODE_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h07;
  localparam logic [DATA_W-1:0] RESET_BLANK = {RESET_ATTR, CODE_SPACE};

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SWEEP_INIT   = 2'd0,
    SWEEP_CLEAR  = 2'd1,
    SWEEP_SCROLL = 2'd2
  } sweep_mode_t;

  typedef struct packed {
    logic        take_item;
    logic        decode;
    logic        cnt_clear;
    logic        sweep_step;
    sweep_mode_t sweep_mode;
    logic        out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scroll_req;
    logic            cnt_last;
    logic            out_free;
  } tcw_sts_t;

endpackage

// ===== design/tcw_in_if.sv =====
// request channel of the console writer: opcode, character and cell index
// depends on tcw_pkg
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output opcode, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input opcode, input char_code, input cell_index,
                output ready);
endinterface

// ===== design/tcw_out_if.sv =====
// response channel of the console writer: cell data and cursor position
// depends on tcw_pkg
interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] cell_data;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;

  modport source (output valid, output cell_data, output cursor_col, output cursor_row,
                  input ready);
  modport sink (input valid, input cell_data, input cursor_col, input cursor_row,
                output ready);
endinterface

// ===== design/tcw_cfg_if.sv =====
// configuration write channel carrying the text attribute byte
// depends on tcw_pkg
interface tcw_cfg_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_attribute;

  modport source (output valid, output text_attribute, input ready);
  modport sink (input valid, input text_attribute, output ready);
endinterface

// ===== design/tcw_ctrl.sv =====
// controller state machine of the console writer: sequences decode, sweeps and result
// depends on tcw_pkg and text_console_writer_unit_defines.svh
`include "text_console_writer_unit_defines.svh"

module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_FILL   = 6'b001000,
    S_SCROLL = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.sweep_mode = SWEEP_INIT;
    state_next = state;
    unique case (state)
      S_INIT: begin
        // power-up blanking pass over the whole store
        cmd.sweep_step = 1'b1;
        cmd.sweep_mode = SWEEP_INIT;
        if (sts.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode    = 1'b1;
        cmd.cnt_clear = 1'b1;
        priority if (sts.op == OP_CLEAR) begin
          state_next = S_FILL;
        end else if (sts.op == OP_PUT && sts.scroll_req) begin
          state_next = S_SCROLL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FILL: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_mode = SWEEP_CLEAR;
        if (sts.cnt_last) state_next = S_DONE;
      end
      S_SCROLL: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_mode = SWEEP_SCROLL;
        if (sts.cnt_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  `TCW_ASSERT(a_load_into_free, clk, rst, cmd.out_load |-> sts.out_free, "result loaded into a full output register")
  `TCW_ASSERT(a_decode_after_take, clk, rst, cmd.decode |-> $past(cmd.take_item), "decode without a preceding item")
  `TCW_ASSERT_ALWAYS(a_no_take_in_reset, clk, rst |-> !cmd.take_item, "item taken during reset")

endmodule

// ===== design/tcw_datapath.sv =====
// console writer datapath: cursor, attribute, screen store, sweep counter, result register
// depends on tcw_pkg and text_console_writer_unit_defines.svh
`include "text_console_writer_unit_defines.svh"

module tcw_datapath import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  tcw_cmd_t          cmd,
  output tcw_sts_t          sts,
  input  logic [OP_W-1:0]   opcode,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [IDX_W-1:0]  cell_index,
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_attr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data,
  output logic [COL_W-1:0]  out_col,
  output logic [ROW_W-1:0]  out_row
);

  logic [DATA_W-1:0] mem [SCREEN_CELLS];

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [ATTR_W-1:0]  attr;
  logic [OP_W-1:0]    op_q;
  logic [CHAR_W-1:0]  ch_q;
  logic [IDX_W-1:0]   idx_q;
  logic               is_read;
  logic [CNT_W-1:0]   cnt;
  logic               pend_valid;
  logic               pend_copy;
  logic [CELL_AW-1:0] pend_addr;
  logic [DATA_W-1:0]  pend_fill;
  logic [DATA_W-1:0]  rdata;

  logic [COL_W-1:0]   col_put;
  logic [ROW_W-1:0]   row_put;
  logic               put_we;
  logic               scroll_req;
  logic               is_put;
  logic               read_ok;
  logic               copy;
  logic [DATA_W-1:0]  fill;
  logic [CELL_AW-1:0] cur_addr;
  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [CELL_AW-1:0] mem_raddr;

  assign is_put   = (op_q == OP_PUT);
  assign read_ok  = (32'(idx_q) < SCREEN_CELLS);
  assign cur_addr = CELL_AW'(row) * CELL_AW'(SCREEN_COLS) + CELL_AW'(col);

  // cursor step for put character
  always_comb begin
    col_put    = col;
    row_put    = row;
    put_we     = 1'b0;
    scroll_req = 1'b0;
    unique case (ch_q)
      CODE_NUL: begin
      end
      CODE_CR: begin
        col_put = '0;
      end
      CODE_LF: begin
        col_put = '0;
        // leaving the last row scrolls, so the row stays put
        if (row == ROW_LAST) scroll_req = 1'b1;
        else row_put = row + 1'b1;
      end
      CODE_BS: begin
        if (col != '0) begin
          col_put = col - 1'b1;
        end else if (row != '0) begin
          col_put = COL_LAST;
          row_put = row - 1'b1;
        end
      end
      default: begin
        put_we = 1'b1;
        if (col == COL_LAST) begin
          col_put = '0;
          if (row == ROW_LAST) scroll_req = 1'b1;
          else row_put = row + 1'b1;
        end else begin
          col_put = col + 1'b1;
        end
      end
    endcase
  end

  // scroll copies cell cnt+cols down to cnt, the bottom row and clears get blanks
  assign copy = (cmd.sweep_mode == SWEEP_SCROLL) && (cnt < COPY_END);
  assign fill = (cmd.sweep_mode == SWEEP_INIT) ? RESET_BLANK : {attr, CODE_SPACE};

  // a sweep write lands in the cycle after its read
  assign mem_we    = pend_valid || (cmd.decode && is_put && put_we);
  assign mem_waddr = pend_valid ? pend_addr : cur_addr;
  assign mem_wdata = pend_valid ? (pend_copy ? rdata : pend_fill) : {attr, ch_q};
  assign mem_re    = (cmd.decode && (op_q == OP_READ) && read_ok) ||
                     (cmd.sweep_step && copy);
  assign mem_raddr = cmd.sweep_step ? CELL_AW'(cnt + ROW_STRIDE) : CELL_AW'(idx_q);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      attr       <= RESET_ATTR;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) attr <= cfg_attr;
      if (cmd.decode && is_put) begin
        col <= col_put;
        row <= row_put;
      end
      if (cmd.cnt_clear) cnt <= '0;
      else if (cmd.sweep_step) cnt <= cnt + 1'b1;
      pend_valid <= cmd.sweep_step;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op_q  <= opcode;
      ch_q  <= char_code;
      idx_q <= cell_index;
    end
    if (cmd.decode) is_read <= (op_q == OP_READ) && read_ok;
    if (cmd.sweep_step) begin
      pend_addr <= CELL_AW'(cnt);
      pend_copy <= copy;
      pend_fill <= fill;
    end
    if (cmd.out_load) begin
      out_data <= is_read ? rdata : '0;
      out_col  <= col;
      out_row  <= row;
    end
  end

  assign sts.op         = op_q;
  assign sts.scroll_req = scroll_req;
  assign sts.cnt_last   = (cnt == CNT_LAST);
  assign sts.out_free   = !out_valid || out_ready;

  `TCW_ASSERT(a_col_range, clk, rst, col <= COL_LAST, "cursor column beyond last column")
  `TCW_ASSERT(a_row_range, clk, rst, row <= ROW_LAST, "cursor row beyond last row")
  `TCW_ASSERT(a_no_write_clash, clk, rst, pend_valid |-> !(cmd.decode && is_put && put_we), "sweep write collides with character write")

endmodule

// ===== design/text_console_writer_unit.sv =====
// Text console writer: an 80 x 25 screen of 16-bit cells (attribute over character)
// with a cursor. Put character, read cell and no-op requests pass from accept through
// decode to the result; a put that scrolls (line feed or wrap on the last row) and a
// clear screen also sweep all SCREEN_CELLS cells: the screen memory (one read
// and one write per cycle) is walked one cell per cycle. After reset a blanking pass
// over all SCREEN_CELLS = 2000 cells fills the screen with 0x0720 while request.ready
// stays low; cfg is always ready. One request is in flight at a time; a new one is
// taken while the previous result waits.
// Depends on tcw_pkg, the three channel interfaces, tcw_ctrl and tcw_datapath.
module text_console_writer_unit import tcw_pkg::*; (
  input logic       clk,
  input logic       rst,
  tcw_in_if.sink    request,
  tcw_out_if.source response,
  tcw_cfg_if.sink   cfg
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  assign cfg.ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (request.opcode),
    .char_code  (request.char_code),
    .cell_index (request.cell_index),
    .cfg_we     (cfg.valid),
    .cfg_attr   (cfg.text_attribute),
    .out_valid  (response.valid),
    .out_ready  (response.ready),
    .out_data   (response.cell_data),
    .out_col    (response.cursor_col),
    .out_row    (response.cursor_row)
  );

endmodule
